// ----- hw/rtl/ssr_pkg.sv -----
// ssr_pkg: shared types and constants for the slope reconstruction block
// holds widths, mode and status codes, the work-queue entry and fsm state types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

    localparam int NV       = 3;                // conserved variables per cell
    localparam int FRAC     = 16;               // fraction bits of q16.16
    localparam int NUM_W    = 84;               // signed numerator width
    localparam int DEN_W    = 68;               // signed denominator width
    localparam int QW       = 32;               // quotient bits produced
    localparam int DSH_W    = DEN_W + QW;       // shifted divisor width
    localparam int MUL_LAST = 8;                // last step of the product sequence
    localparam int QUEUE_DEPTH = 2;             // power of two
    localparam int QP_W     = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_LS   = 2'd1;
    localparam logic [1:0] MODE_CD   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ZERO_DEN,
        ST_SAT,
        ST_SHORT
    } status_t;

    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic signed [DEN_W-1:0] den_t;

    // one quotient job handed from front to back
    typedef struct packed {
        num_t [NV-1:0] num;
        den_t          den;
        logic          zero;
        status_t       status;
        logic          run_end;
        logic          grid_end;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_INT,
        F_EDGE1,
        F_EDGE2
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CHECK,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssr_if.sv -----
// ssr_if: valid/ready channel interfaces for cells, slopes and the mode register
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface ssr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cell_centre;
    logic [30:0]        cell_width;
    logic signed [31:0] var_a;
    logic signed [31:0] var_b;
    logic signed [31:0] var_c;
    logic               stream_last;

    modport source (output valid, cell_centre, cell_width, var_a, var_b, var_c,
                    stream_last, input ready);
    modport sink (input valid, cell_centre, cell_width, var_a, var_b, var_c,
                  stream_last, output ready);
endinterface

interface ssr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] slope_a;
    logic signed [31:0] slope_b;
    logic signed [31:0] slope_c;
    logic               run_end;
    logic               grid_end;
    logic [1:0]         status;

    modport source (output valid, slope_a, slope_b, slope_c, run_end, grid_end,
                    status, input ready);
    modport sink (input valid, slope_a, slope_b, slope_c, run_end, grid_end,
                  status, output ready);
endinterface

interface ssr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] slope_mode;

    modport source (output valid, slope_mode, input ready);
    modport sink (input valid, slope_mode, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ssr_queue.sv -----
// ssr_queue: short fifo of quotient jobs between front and back
// depends on ssr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssr_queue
    import ssr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t            mem_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W:0]   cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (cnt_reg != (QP_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ssr_front.sv -----
// ssr_front: takes cells, keeps the three-cell window and builds quotient jobs
// depends on ssr_pkg and ssr_if; one shared 33x33 multiplier for least squares
`timescale 1ns / 1ps
`default_nettype none

module ssr_front
    import ssr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] slope_mode,
    ssr_in_if.sink     cell_in,
    output logic       push_valid,
    input  logic       push_ready,
    output job_t       push_job
);

    front_state_t state_reg, state_next;

    // window: slot 0 older, slot 1 newer
    logic signed [31:0] x0_reg, x1_reg;
    logic [30:0]        w1_reg;
    logic signed [31:0] v0_reg [NV];
    logic signed [31:0] v1_reg [NV];
    logic [1:0]         count_reg;

    logic signed [32:0] du_m_reg [NV];
    logic signed [32:0] du_p_reg [NV];
    logic signed [32:0] dm_reg, dp_reg;
    logic [30:0]        wc_reg;
    logic               last_reg;
    logic [1:0]         n_reg;

    logic [3:0]         step_reg;
    logic signed [65:0] prod_reg;
    logic signed [66:0] acc_reg [NV];
    logic signed [66:0] den_reg;

    logic signed [31:0] v_in [NV];
    logic signed [32:0] mul_a, mul_b;
    logic [1:0]         n_in;
    logic               accept;

    assign v_in[0] = cell_in.var_a;
    assign v_in[1] = cell_in.var_b;
    assign v_in[2] = cell_in.var_c;
    assign n_in    = count_reg[1] ? 2'd2 : count_reg;
    assign accept  = (state_reg == F_IDLE) && cell_in.valid;

    // operand select for the product sequence
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0: begin mul_a = du_m_reg[0]; mul_b = dm_reg; end
            4'd1: begin mul_a = du_m_reg[1]; mul_b = dm_reg; end
            4'd2: begin mul_a = du_m_reg[2]; mul_b = dm_reg; end
            4'd3: begin mul_a = du_p_reg[0]; mul_b = dp_reg; end
            4'd4: begin mul_a = du_p_reg[1]; mul_b = dp_reg; end
            4'd5: begin mul_a = du_p_reg[2]; mul_b = dp_reg; end
            4'd6: begin mul_a = dm_reg;      mul_b = dm_reg; end
            4'd7: begin mul_a = dp_reg;      mul_b = dp_reg; end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < NV; j++)
            begin
                du_m_reg[j] <= 33'(v0_reg[j]) - 33'(v1_reg[j]);
                du_p_reg[j] <= 33'(v_in[j]) - 33'(v1_reg[j]);
            end
            dm_reg   <= 33'(x0_reg) - 33'(x1_reg);
            dp_reg   <= 33'(cell_in.cell_centre) - 33'(x1_reg);
            wc_reg   <= w1_reg;
            last_reg <= cell_in.stream_last;
            n_reg    <= n_in;
            if (!cell_in.stream_last)
            begin
                x0_reg <= x1_reg;
                x1_reg <= cell_in.cell_centre;
                w1_reg <= cell_in.cell_width;
                for (int j = 0; j < NV; j++)
                begin
                    v0_reg[j] <= v1_reg[j];
                    v1_reg[j] <= v_in[j];
                end
            end
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= mul_a * mul_b;
            // product of the previous step is folded in here
            case (step_reg)
                4'd1: acc_reg[0] <= 67'(prod_reg);
                4'd2: acc_reg[1] <= 67'(prod_reg);
                4'd3: acc_reg[2] <= 67'(prod_reg);
                4'd4: acc_reg[0] <= acc_reg[0] + 67'(prod_reg);
                4'd5: acc_reg[1] <= acc_reg[1] + 67'(prod_reg);
                4'd6: acc_reg[2] <= acc_reg[2] + 67'(prod_reg);
                4'd7: den_reg    <= 67'(prod_reg);
                4'd8: den_reg    <= den_reg + 67'(prod_reg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                step_reg <= '0;
                if (cell_in.stream_last)
                begin
                    count_reg <= '0;
                end
                else
                begin
                    count_reg <= (n_in == 2'd0) ? 2'd1 : 2'd2;
                end
            end
            else if (state_reg == F_MUL)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (cell_in.valid)
                begin
                    if (n_in == 2'd0)
                    begin
                        state_next = cell_in.stream_last ? F_INT : F_IDLE;
                    end
                    else if (n_in == 2'd1)
                    begin
                        state_next = F_EDGE1;
                    end
                    else if (slope_mode == MODE_LS)
                    begin
                        state_next = F_MUL;
                    end
                    else
                    begin
                        state_next = F_INT;
                    end
                end
            end
            F_MUL:
            begin
                if (step_reg == 4'(MUL_LAST))
                begin
                    state_next = F_INT;
                end
            end
            F_INT:
            begin
                if (push_ready)
                begin
                    state_next = (last_reg && n_reg == 2'd2) ? F_EDGE2 : F_IDLE;
                end
            end
            F_EDGE1:
            begin
                if (push_ready)
                begin
                    state_next = last_reg ? F_EDGE2 : F_IDLE;
                end
            end
            F_EDGE2:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        cell_in.ready = 1'b0;
        push_valid    = 1'b0;
        push_job      = '0;
        push_job.status = ST_OK;
        case (state_reg)
            F_IDLE: cell_in.ready = 1'b1;
            F_INT:
            begin
                push_valid       = 1'b1;
                push_job.run_end = !last_reg;
                if (n_reg == 2'd0)
                begin
                    // a single cell that is already the last one
                    push_job.zero     = 1'b1;
                    push_job.status   = ST_SHORT;
                    push_job.run_end  = 1'b1;
                    push_job.grid_end = 1'b1;
                end
                else if (slope_mode == MODE_LS)
                begin
                    for (int j = 0; j < NV; j++)
                    begin
                        push_job.num[j] = NUM_W'(acc_reg[j]) <<< FRAC;
                    end
                    push_job.den = DEN_W'(den_reg);
                end
                else if (slope_mode == MODE_CD)
                begin
                    for (int j = 0; j < NV; j++)
                    begin
                        push_job.num[j] =
                            NUM_W'(34'(du_p_reg[j]) - 34'(du_m_reg[j])) <<< FRAC;
                    end
                    push_job.den = DEN_W'({1'b0, wc_reg, 1'b0});
                end
                else
                begin
                    push_job.zero = 1'b1;
                end
            end
            F_EDGE1, F_EDGE2:
            begin
                push_valid        = 1'b1;
                push_job.run_end  = (state_reg == F_EDGE2) || !last_reg;
                push_job.grid_end = (state_reg == F_EDGE2);
                if (slope_mode == MODE_LS || slope_mode == MODE_CD)
                begin
                    for (int j = 0; j < NV; j++)
                    begin
                        push_job.num[j] = NUM_W'(du_p_reg[j]) <<< FRAC;
                    end
                    push_job.den = DEN_W'(dp_reg);
                end
                else
                begin
                    push_job.zero = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ssr_back.sv -----
// ssr_back: three-lane radix-2 divider with saturation and the output register
// depends on ssr_pkg and ssr_if
`timescale 1ns / 1ps
`default_nettype none

module ssr_back
    import ssr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    output logic pop_ready,
    input  job_t pop_job,
    ssr_out_if.source slope_out
);

    back_state_t state_reg, state_next;

    logic [NUM_W-1:0] rem_reg [NV];
    logic [QW-1:0]    q_reg [NV];
    logic [NV-1:0]    neg_reg;
    logic [NV-1:0]    ovf_reg;
    logic [DEN_W-1:0] dmag_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic             dzero_reg;
    logic             zero_reg;
    status_t          status_reg;
    logic             run_reg;
    logic             grid_reg;
    logic [4:0]       cnt_reg;

    logic               out_valid_reg;
    logic signed [31:0] slope_reg [NV];
    logic               run_out_reg;
    logic               grid_out_reg;
    status_t            status_out_reg;

    logic               out_free;
    logic               load_out;
    logic signed [31:0] slope_res [NV];
    status_t            status_res;

    assign out_free = !out_valid_reg || slope_out.ready;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    for (int j = 0; j < NV; j++)
                    begin
                        rem_reg[j] <= pop_job.num[j][NUM_W-1] ? -pop_job.num[j]
                                                              : pop_job.num[j];
                        neg_reg[j] <= pop_job.num[j][NUM_W-1] ^ pop_job.den[DEN_W-1];
                    end
                    dmag_reg   <= pop_job.den[DEN_W-1] ? -pop_job.den : pop_job.den;
                    dzero_reg  <= (pop_job.den == '0);
                    zero_reg   <= pop_job.zero;
                    status_reg <= pop_job.status;
                    run_reg    <= pop_job.run_end;
                    grid_reg   <= pop_job.grid_end;
                end
            end
            B_CHECK:
            begin
                // quotient of 2^32 or more always saturates
                for (int j = 0; j < NV; j++)
                begin
                    ovf_reg[j] <= DSH_W'(rem_reg[j]) >= {dmag_reg, {QW{1'b0}}};
                    q_reg[j]   <= '0;
                end
                dsh_reg <= {1'b0, dmag_reg, {(QW-1){1'b0}}};
                cnt_reg <= 5'(QW-1);
            end
            B_DIV:
            begin
                for (int j = 0; j < NV; j++)
                begin
                    if (DSH_W'(rem_reg[j]) >= dsh_reg)
                    begin
                        rem_reg[j] <= NUM_W'(DSH_W'(rem_reg[j]) - dsh_reg);
                        q_reg[j]   <= {q_reg[j][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[j] <= {q_reg[j][QW-2:0], 1'b0};
                    end
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        logic any_sat;
        logic sat;
        any_sat = 1'b0;
        for (int j = 0; j < NV; j++)
        begin
            sat = ovf_reg[j] ||
                  (q_reg[j] > (neg_reg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF));
            any_sat = any_sat || sat;
            if (sat)
            begin
                slope_res[j] = neg_reg[j] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            else
            begin
                slope_res[j] = neg_reg[j] ? -$signed(q_reg[j]) : $signed(q_reg[j]);
            end
        end
        status_res = any_sat ? ST_SAT : ST_OK;
        if (zero_reg || dzero_reg)
        begin
            for (int j = 0; j < NV; j++)
            begin
                slope_res[j] = '0;
            end
            status_res = zero_reg ? status_reg : ST_ZERO_DEN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int j = 0; j < NV; j++)
            begin
                slope_reg[j] <= slope_res[j];
            end
            run_out_reg    <= run_reg;
            grid_out_reg   <= grid_reg;
            status_out_reg <= status_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (slope_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (pop_valid) state_next = B_CHECK;
            B_CHECK: state_next = (zero_reg || dzero_reg) ? B_OUT : B_DIV;
            B_DIV:   if (cnt_reg == '0) state_next = B_OUT;
            B_OUT:   if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready = (state_reg == B_IDLE);
        load_out  = (state_reg == B_OUT) && out_free;
    end

    assign slope_out.valid    = out_valid_reg;
    assign slope_out.slope_a  = slope_reg[0];
    assign slope_out.slope_b  = slope_reg[1];
    assign slope_out.slope_c  = slope_reg[2];
    assign slope_out.run_end  = run_out_reg;
    assign slope_out.grid_end = grid_out_reg;
    assign slope_out.status   = status_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/stencil_slope_reconstruction.sv -----
// stencil_slope_reconstruction: streaming 1d slope reconstruction, top level
// depends on ssr_pkg, ssr_if, ssr_front, ssr_queue, ssr_back
//
// cells arrive on cell_in in grid order, ghost cells included, the final one
// marked by stream_last. each cell after the first gives one slope request on
// slope_out, one cell behind; the final cell gives a second request carrying
// grid_end. run_end marks the last request caused by a cell. cfg writes
// slope_mode (0 zero, 1 least squares, 2 central difference) and is always
// ready; write it only while the block is idle.
// in the back end a slope request passes the pop, the range check, 32 quotient
// steps and the output load; a zero request or a zero denominator skips the
// quotient steps. a least-squares interior cell first runs the product
// sequence in the front end. the front and back meet in a two-entry job queue,
// so the front takes the next cell while the divider works, as long as the
// queue has room.
// a stalled receiver holds the output register, then the divider, then the
// queue, and finally cell_in.ready drops.
// reset empties the window, queue and output and sets least-squares mode.
`timescale 1ns / 1ps
`default_nettype none

module stencil_slope_reconstruction
    import ssr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ssr_in_if.sink    cell_in,
    ssr_out_if.source slope_out,
    ssr_cfg_if.sink   cfg
);

    logic [1:0] mode_reg;
    logic       push_valid;
    logic       push_ready;
    job_t       push_job;
    logic       pop_valid;
    logic       pop_ready;
    job_t       pop_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LS;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.slope_mode;
        end
    end

    ssr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .slope_mode (mode_reg),
        .cell_in    (cell_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    ssr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .slope_out (slope_out)
    );

    a_short_ends: assert property (@(posedge clk) disable iff (!rst_n)
        slope_out.valid && slope_out.status == ST_SHORT
        |-> slope_out.run_end && slope_out.grid_end)
        else $error("short-stream result without end marks");

    a_grid_run: assert property (@(posedge clk) disable iff (!rst_n)
        slope_out.valid && slope_out.grid_end |-> slope_out.run_end)
        else $error("grid_end without run_end");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        slope_out.valid && slope_out.status == ST_ZERO_DEN
        |-> slope_out.slope_a == 0 && slope_out.slope_b == 0 && slope_out.slope_c == 0)
        else $error("zero denominator with nonzero slope");

endmodule

`default_nettype wire
